FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers. Define ASSERT_OFF to compile them out.
// The using module must have i_clk and i_rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge out of reset
`define BTL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Condition must never be seen at a clock edge out of reset
`define BTL_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define BTL_ASSERT(label, prop, msg)
`define BTL_ASSERT_NEVER(label, cond, msg)
`endif

`endif

FILE: rtl/core/btl_pkg.sv
// ----------------------------------------------------------------------------
// btl_pkg
// Shared types and constants of the branch target locator.
// ----------------------------------------------------------------------------
package btl_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int NEAR_RANGE  = 9;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = 11;
    localparam int LOC_W  = 32;
    localparam int POS_W  = CNT_W + 1;
    localparam int NEAR_W = $clog2(NEAR_RANGE + 2);
    localparam int WORD_W = LOC_W + 1;

    typedef enum logic [1:0] {
        ACT_LOAD      = 2'd0,
        ACT_RESOLVE   = 2'd1,
        ACT_READ_MARK = 2'd2
    } t_action;

    typedef struct packed {
        logic [1:0]       action;
        logic [IDX_W-1:0] entry_index;
        logic [LOC_W-1:0] location_value;
    } t_request;

    typedef struct packed {
        logic             status;
        logic [IDX_W-1:0] result_index;
        logic             mark_bit;
    } t_result;

    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [WORD_W-1:0] wr_data;
    } t_mem_req;

    typedef struct packed {
        logic in_ready;
        logic res_valid;
    } t_ctrl_status;

    localparam t_result RES_MISS = '{status: 1'b1, result_index: '0, mark_bit: 1'b0};

endpackage

FILE: rtl/core/btl_table_ram.sv
// ----------------------------------------------------------------------------
// btl_table_ram
// Single-port-read, single-port-write table: mark bit over location word.
// ----------------------------------------------------------------------------
module btl_table_ram
    import btl_pkg::*;
(
    input  logic              i_clk,
    input  t_mem_req          i_req,
    output logic [WORD_W-1:0] o_rd_data
);

    logic [WORD_W-1:0] r_mem [TABLE_DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/btl_search_ctrl.sv
// ----------------------------------------------------------------------------
// btl_search_ctrl
// Sequencer: clearing pass, loads, mark reads and the halving/neighbour search.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module btl_search_ctrl
    import btl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CNT_W-1:0]  i_count,
    input  logic              i_req_valid,
    input  t_request          i_req,
    input  logic              i_res_take,
    input  logic [WORD_W-1:0] i_rd_data,
    output t_mem_req          o_mem,
    output t_ctrl_status      o_status,
    output t_result           o_res
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_SEARCH = 6'b000100,
        S_NEAR   = 6'b001000,
        S_READ   = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_clr_addr, n_clr_addr;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [POS_W-1:0]  r_step, n_step;
    logic [POS_W-1:0]  r_cand, n_cand;
    logic [NEAR_W-1:0] r_dist, n_dist;
    logic              r_down, n_down;
    logic [LOC_W-1:0]  r_target, n_target;
    logic [IDX_W-1:0]  r_index, n_index;
    t_result           r_res, n_res;

    t_mem_req          mem_req;
    logic [POS_W-1:0]  cnt_ext;
    logic [LOC_W-1:0]  rd_loc;
    logic              rd_mark;
    logic              rd_hit;
    logic              rd_above;
    logic [POS_W-1:0]  new_pos;
    logic              new_ok;
    logic [POS_W-1:0]  cand_nx;
    logic [NEAR_W-1:0] dist_nx;
    logic              cand_ok;

    assign cnt_ext  = {1'b0, i_count};
    assign rd_loc   = i_rd_data[LOC_W-1:0];
    assign rd_mark  = i_rd_data[LOC_W];
    assign rd_hit   = (rd_loc == r_target);
    assign rd_above = (rd_loc > r_target);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_step   <= n_step;
        r_cand   <= n_cand;
        r_dist   <= n_dist;
        r_down   <= n_down;
        r_target <= n_target;
        r_index  <= n_index;
        r_res    <= n_res;
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_pos      = r_pos;
        n_step     = r_step;
        n_cand     = r_cand;
        n_dist     = r_dist;
        n_down     = r_down;
        n_target   = r_target;
        n_index    = r_index;
        n_res      = r_res;
        mem_req    = '0;
        new_pos    = '0;
        new_ok     = 1'b0;
        cand_nx    = '0;
        dist_nx    = '0;
        cand_ok    = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_clr_addr;
                n_clr_addr      = r_clr_addr + IDX_W'(1);
                if (r_clr_addr == {IDX_W{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_target = i_req.location_value;
                    n_index  = i_req.entry_index;
                    unique case (i_req.action)
                        ACT_LOAD: begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = i_req.entry_index;
                            mem_req.wr_data = {1'b0, i_req.location_value};
                            n_res   = '{status: 1'b0, result_index: i_req.entry_index,
                                        mark_bit: 1'b0};
                            n_state = S_EMIT;
                        end
                        ACT_RESOLVE: begin
                            if (i_count == '0) begin
                                n_res   = RES_MISS;
                                n_state = S_EMIT;
                            end else begin
                                n_pos           = {2'b00, i_count[CNT_W-1:1]};
                                n_step          = {3'b000, i_count[CNT_W-1:2]};
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = i_count[IDX_W:1];
                                n_state         = S_SEARCH;
                            end
                        end
                        ACT_READ_MARK: begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = i_req.entry_index;
                            n_state         = S_READ;
                        end
                        default: begin
                            n_res   = '0;
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_res   = '{status: 1'b0, result_index: r_index, mark_bit: rd_mark};
                n_state = S_EMIT;
            end
            S_SEARCH: begin
                if (rd_hit) begin
                    // set the mark, keep the location
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = r_pos[IDX_W-1:0];
                    mem_req.wr_data = {1'b1, r_target};
                    n_res   = '{status: 1'b0, result_index: r_pos[IDX_W-1:0], mark_bit: 1'b1};
                    n_state = S_EMIT;
                end else if (r_step == '0) begin
                    // first neighbour on the side of the target
                    cand_nx = rd_above ? (r_pos - POS_W'(1)) : (r_pos + POS_W'(1));
                    cand_ok = rd_above ? (r_pos != '0) : (cand_nx < cnt_ext);
                    if (cand_ok) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = cand_nx[IDX_W-1:0];
                        n_cand  = cand_nx;
                        n_dist  = NEAR_W'(1);
                        n_down  = rd_above;
                        n_state = S_NEAR;
                    end else begin
                        n_res   = RES_MISS;
                        n_state = S_EMIT;
                    end
                end else begin
                    if (rd_above) begin
                        new_pos = r_pos - r_step;
                        new_ok  = (r_step <= r_pos);
                    end else begin
                        new_pos = r_pos + r_step;
                        new_ok  = (new_pos < cnt_ext);
                    end
                    if (new_ok) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = new_pos[IDX_W-1:0];
                        n_pos  = new_pos;
                        n_step = r_step >> 1;
                    end else begin
                        n_res   = RES_MISS;
                        n_state = S_EMIT;
                    end
                end
            end
            S_NEAR: begin
                if (rd_hit) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = r_cand[IDX_W-1:0];
                    mem_req.wr_data = {1'b1, r_target};
                    n_res   = '{status: 1'b0, result_index: r_cand[IDX_W-1:0], mark_bit: 1'b1};
                    n_state = S_EMIT;
                end else begin
                    dist_nx = r_dist + NEAR_W'(1);
                    cand_nx = r_down ? (r_cand - POS_W'(1)) : (r_cand + POS_W'(1));
                    cand_ok = (dist_nx <= NEAR_W'(NEAR_RANGE)) &&
                              (r_down ? (r_cand != '0) : (cand_nx < cnt_ext));
                    if (cand_ok) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = cand_nx[IDX_W-1:0];
                        n_cand = cand_nx;
                        n_dist = dist_nx;
                    end else begin
                        n_res   = RES_MISS;
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_mem              = mem_req;
    assign o_status.in_ready  = (r_state == S_IDLE);
    assign o_status.res_valid = (r_state == S_EMIT);
    assign o_res              = r_res;

    `BTL_ASSERT_NEVER(a_rw_same_entry, mem_req.rd_en && mem_req.wr_en && (mem_req.rd_addr == mem_req.wr_addr), "read and write of one entry in one cycle")
    `BTL_ASSERT(a_probe_in_range, (r_state == S_SEARCH) |-> (r_pos < cnt_ext), "halving probe outside live entries")
    `BTL_ASSERT(a_near_bounded, (r_state == S_NEAR) |-> ((r_dist != '0) && (r_dist <= NEAR_W'(NEAR_RANGE))), "neighbour distance out of range")
    `BTL_ASSERT(a_hit_sets_mark, (mem_req.wr_en && ((r_state == S_SEARCH) || (r_state == S_NEAR))) |-> mem_req.wr_data[LOC_W], "resolve write without mark")

endmodule

FILE: rtl/core/branch_target_locator.sv
// Steps: a load writes its entry as it is taken; a mark read forms its result from
//   the table read; every result then passes into the output register.
// Throughput: one item at a time, the next taken once the result has left the
//   sequencer; each probe is one table read (up to ten halving, nine neighbour).
// Reset: synchronous, active low; then a clearing pass over every entry zeroes the
//   table and no item is taken until it ends. Config writes are taken at any time.
// ----------------------------------------------------------------------------
// branch_target_locator
// Table of instruction locations with a branch-target mark per entry: load,
// resolve by halving search with a short neighbour scan, and mark read.
// ----------------------------------------------------------------------------
module branch_target_locator
    import btl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration write channel
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_entry_count,
    // input item channel
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_action,
    input  logic [IDX_W-1:0] i_entry_index,
    input  logic [LOC_W-1:0] i_location_value,
    // result channel
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_status,
    output logic [IDX_W-1:0] o_result_index,
    output logic             o_mark_bit
);

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  live_count;
    logic              r_out_valid;
    t_result           r_out;
    t_request          req;
    t_mem_req          mem_req;
    logic [WORD_W-1:0] rd_data;
    t_ctrl_status      ctrl_st;
    t_result           ctrl_res;
    logic              res_take;

    // Entry count register; writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_valid) begin
            r_count <= i_cfg_entry_count;
        end
    end

    // Clamp the count to the table depth
    assign live_count = (r_count > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : r_count;

    assign req.action         = i_action;
    assign req.entry_index    = i_entry_index;
    assign req.location_value = i_location_value;

    btl_table_ram u_table (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    btl_search_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_count     (live_count),
        .i_req_valid (i_in_valid),
        .i_req       (req),
        .i_res_take  (res_take),
        .i_rd_data   (rd_data),
        .o_mem       (mem_req),
        .o_status    (ctrl_st),
        .o_res       (ctrl_res)
    );

    assign o_in_ready = ctrl_st.in_ready;

    // Output register: take a finished result whenever the slot is free or
    // being emptied, so the sequencer returns to idle while the result waits
    assign res_take = ctrl_st.res_valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Hold the payload while the transfer out is stalled
    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= ctrl_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_result_index = r_out.result_index;
    assign o_mark_bit     = r_out.mark_bit;

endmodule

FILE: verif/branch_target_locator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// branch_target_locator_tb
// Self-checking bench for the branch target locator. A stimulus process
// queues load, resolve, read-mark and spare requests phase by phase, each
// phase under its own entry count. Most phases rebuild an ascending table
// and resolve targets taken from it. A clocked driver offers the queued
// requests and a clocked monitor compares each result transfer, field by
// field, with the outcome worked out by a mirror of the table and marks.
// ----------------------------------------------------------------------------
module branch_target_locator_tb;
    import btl_pkg::*;

    // Action code that the block leaves unused
    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam int ITEM_TARGET = 1750;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_count = '0;

    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [1:0]       in_action = '0;
    logic [IDX_W-1:0] in_index = '0;
    logic [LOC_W-1:0] in_location = '0;

    logic             out_valid;
    logic             out_ready = 1'b0;
    logic             res_status;
    logic [IDX_W-1:0] res_index;
    logic             res_mark;

    // Requests waiting to be offered, and outcomes waiting for their result
    t_request request_q[$];
    t_result  awaited_results[$];

    // Mirror of the block: location table, branch-target marks, entry count
    logic [LOC_W-1:0] loc_table [TABLE_DEPTH] = '{default: '0};
    bit               mark_table [TABLE_DEPTH];
    logic [CNT_W-1:0] count_reg = '0;

    // What the stimulus has arranged so far, ahead of the transfers
    logic [LOC_W-1:0] staged_loc [TABLE_DEPTH];

    bit in_taken = 1'b0;
    bit gap_free = 1'b0;
    bit held_once = 1'b0;
    int hold_left = 0;
    int mismatches = 0;
    int pushed_items = 0;

    t_request taken_req;
    t_result  got_res;
    t_result  want_res;

    branch_target_locator i_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_entry_count (cfg_count),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_action          (in_action),
        .i_entry_index     (in_index),
        .i_location_value  (in_location),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_status          (res_status),
        .o_result_index    (res_index),
        .o_mark_bit        (res_mark)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Halving search over the live entries, then a short scan of the
    // neighbours on the side of the target. Indices outside the live part
    // of the table count as misses.
    function automatic void find_target(input logic [LOC_W-1:0] target,
                                        output logic found,
                                        output logic [IDX_W-1:0] hit);
        int unsigned cnt, pos, step, d;
        logic [LOC_W-1:0] probe;
        found = 1'b0;
        hit = '0;
        cnt = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : count_reg;
        if (cnt == 0)
            return;
        pos = cnt / 2;
        step = cnt / 4;
        while (pos < cnt) begin
            probe = loc_table[pos];
            if (probe == target) begin
                found = 1'b1;
                hit = IDX_W'(pos);
                return;
            end
            if (step == 0) begin
                for (d = 1; d <= NEAR_RANGE; d++) begin
                    if (probe > target) begin
                        if (d > pos)
                            break;
                        if (loc_table[pos - d] == target) begin
                            found = 1'b1;
                            hit = IDX_W'(pos - d);
                            return;
                        end
                    end else begin
                        if (pos + d >= cnt)
                            break;
                        if (loc_table[pos + d] == target) begin
                            found = 1'b1;
                            hit = IDX_W'(pos + d);
                            return;
                        end
                    end
                end
                return;
            end
            if (probe > target) begin
                if (step > pos)
                    return;
                pos -= step;
            end else begin
                pos += step;
            end
            step /= 2;
        end
    endfunction

    // Apply one request to the mirror and return the result it must give
    function automatic t_result step_locator(input t_request req);
        t_result res;
        logic hit_found;
        logic [IDX_W-1:0] hit_index;
        res = '0;
        case (req.action)
            ACT_LOAD: begin
                loc_table[req.entry_index] = req.location_value;
                mark_table[req.entry_index] = 1'b0;
                res.result_index = req.entry_index;
            end
            ACT_RESOLVE: begin
                find_target(req.location_value, hit_found, hit_index);
                if (hit_found) begin
                    mark_table[hit_index] = 1'b1;
                    res.result_index = hit_index;
                    res.mark_bit = 1'b1;
                end else begin
                    res.status = 1'b1;
                end
            end
            ACT_READ_MARK: begin
                res.result_index = req.entry_index;
                res.mark_bit = mark_table[req.entry_index];
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic void push_item(input logic [1:0] act, input logic [IDX_W-1:0] idx,
                                      input logic [LOC_W-1:0] loc);
        t_request req;
        req.action = act;
        req.entry_index = idx;
        req.location_value = loc;
        request_q.push_back(req);
        if (act == ACT_LOAD)
            staged_loc[idx] = loc;
        pushed_items++;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Hold until every queued request has gone in and every result is out
    task automatic settle();
        while (request_q.size() != 0 || in_valid || awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the entry count; only called with the block idle
    task automatic write_count(input logic [CNT_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_count <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        count_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Driver: advance to the next request once the current one is transferred,
    // sometimes leaving a gap
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (request_q.size() != 0 && (gap_free || $urandom_range(0, 99) >= 7)) begin
                taken_req = request_q.pop_front();
                in_valid <= 1'b1;
                in_action <= taken_req.action;
                in_index <= taken_req.entry_index;
                in_location <= taken_req.location_value;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Input monitor: each transfer in updates the mirror and queues its outcome
    always @(posedge clk) begin
        in_taken = rst_n && in_valid && in_ready;
        if (in_taken) begin
            awaited_results.push_back(step_locator('{action: in_action,
                                                     entry_index: in_index,
                                                     location_value: in_location}));
        end
    end

    // Receiver: random stalls, plus one long hold-off while plenty of requests
    // are queued so that the block backs up onto its input
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (!held_once && request_q.size() > 200) begin
            held_once = 1'b1;
            hold_left = 400;
            out_ready <= 1'b0;
        end else begin
            out_ready <= gap_free || ($urandom_range(0, 99) >= 7);
        end
    end

    // Output monitor: compare each result transfer with the oldest outcome
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            got_res.status = res_status;
            got_res.result_index = res_index;
            got_res.mark_bit = res_mark;
            if (awaited_results.size() == 0) begin
                $error("result transfer with no request outstanding");
                mismatches++;
            end else begin
                want_res = awaited_results.pop_front();
                check_field("status", want_res.status, got_res.status);
                check_field("result_index", want_res.result_index, got_res.result_index);
                check_field("mark_bit", want_res.mark_bit, got_res.mark_bit);
            end
        end
    end

    // Stimulus
    initial begin
        int unsigned phase, live, ops, n, i, roll;
        logic [CNT_W-1:0] count_val;
        logic [IDX_W-1:0] idx;
        logic [LOC_W-1:0] loc, span;

        for (i = 0; i < TABLE_DEPTH; i++)
            staged_loc[i] = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty table: every resolve misses; marks read as clear
        push_item(ACT_RESOLVE, '0, '0);
        push_item(ACT_RESOLVE, '1, '1);
        push_item(ACT_READ_MARK, '0, '0);
        push_item(ACT_READ_MARK, '1, '1);
        push_item(ACT_SPARE, '1, '1);
        push_item(ACT_LOAD, '1, '1);
        push_item(ACT_LOAD, '0, '0);
        push_item(ACT_READ_MARK, '1, '0);
        settle();

        // One entry: a hit sets its mark, a reload clears it, a scan past
        // the end of the table misses
        write_count(CNT_W'(1));
        push_item(ACT_RESOLVE, '0, '0);
        push_item(ACT_RESOLVE, '0, 32'd1);
        push_item(ACT_READ_MARK, '0, '0);
        push_item(ACT_LOAD, '0, '0);
        push_item(ACT_READ_MARK, '0, '0);
        push_item(ACT_SPARE, '0, '0);
        settle();

        // Two entries: direct hit, hit one step below, and a miss
        write_count(CNT_W'(2));
        push_item(ACT_LOAD, IDX_W'(1), '1);
        push_item(ACT_RESOLVE, '0, '1);
        push_item(ACT_RESOLVE, '0, '0);
        push_item(ACT_RESOLVE, '0, 32'd5);
        push_item(ACT_READ_MARK, IDX_W'(1), '0);
        push_item(ACT_READ_MARK, '0, '0);
        settle();

        // Random phases, each under its own entry count
        pushed_items = 0;
        phase = 0;
        while (pushed_items < ITEM_TARGET) begin
            case (phase)
                0: count_val = CNT_W'(1);
                1: count_val = CNT_W'(2);
                3: count_val = CNT_W'(TABLE_DEPTH);
                4: count_val = '1;
                5: count_val = '0;
                default: begin
                    if ($urandom_range(0, 9) == 0)
                        count_val = CNT_W'($urandom_range(65, 300));
                    else
                        count_val = CNT_W'($urandom_range(3, 64));
                end
            endcase
            live = (count_val > TABLE_DEPTH) ? TABLE_DEPTH : count_val;
            write_count(count_val);
            gap_free = (phase == 2);

            // Rebuild the live part as an ascending table with the odd
            // repeated value; the oversized count reuses the full table
            if (phase != 4 && live != 0) begin
                span = 32'hFFFF_FFFF / (live + 1);
                loc = $urandom_range(0, span);
                for (i = 0; i < live; i++) begin
                    push_item(ACT_LOAD, IDX_W'(i), loc);
                    if ($urandom_range(0, 9) != 0)
                        loc = loc + $urandom_range(1, span);
                end
            end

            ops = $urandom_range(40, 150);
            for (n = 0; n < ops; n++) begin
                roll = $urandom_range(0, 99);
                idx = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
                loc = $urandom();
                if (roll < 55) begin
                    // target present in the table, if any entries are live
                    if (live != 0)
                        loc = staged_loc[$urandom_range(0, live - 1)];
                    push_item(ACT_RESOLVE, idx, loc);
                end else if (roll < 67) begin
                    // target just off a stored value, or anywhere
                    if (live != 0 && roll[0])
                        loc = staged_loc[$urandom_range(0, live - 1)] + 1;
                    push_item(ACT_RESOLVE, idx, loc);
                end else if (roll < 80) begin
                    if (live != 0 && roll[0])
                        idx = IDX_W'($urandom_range(0, live - 1));
                    push_item(ACT_READ_MARK, idx, loc);
                end else if (roll < 94) begin
                    // stray load, which may break the ordering
                    if (live != 0 && roll[0])
                        idx = IDX_W'($urandom_range(0, live - 1));
                    push_item(ACT_LOAD, idx, loc);
                end else begin
                    push_item(ACT_SPARE, idx, loc);
                end
            end
            settle();
            gap_free = 1'b0;
            phase++;
        end

        repeat (30) @(posedge clk);
        if (mismatches == 0)
            $display("branch_target_locator test passed");
        else
            $display("branch_target_locator test failed");
        $finish;
    end

    // Watchdog
    initial begin
        #6_000_000;
        $display("branch_target_locator test failed");
        $finish;
    end

endmodule

FILE: branch_target_locator.f
+incdir+rtl/core
rtl/core/btl_pkg.sv
rtl/core/btl_table_ram.sv
rtl/core/btl_search_ctrl.sv
rtl/core/branch_target_locator.sv
verif/branch_target_locator_tb.sv
